[rtl/vlpd_pkg.sv]
// shared types and constants for the varint length-prefixed deframer
package vlpd_pkg;

	localparam int unsigned LEN_W = 30;
	localparam int unsigned ACC_W = 64;
	localparam int unsigned SHIFT_W = 7;

	localparam logic [LEN_W-1:0] MAX_FRAME_LEN_RST = 30'd1000000000;

	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_LENGTH = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [1:0] ERR_TOO_LONG = 2'd0;
	localparam logic [1:0] ERR_ZERO = 2'd1;
	localparam logic [1:0] ERR_TOO_LARGE = 2'd2;

	typedef struct packed {
		logic [1:0] out_kind;
		logic [7:0] out_byte;
		logic [LEN_W-1:0] frame_length;
		logic last;
		logic [1:0] err_code;
	} result_t;

endpackage

[rtl/vlpd_if.sv]
// channel interfaces: input byte stream, result stream, register write
interface vlpd_in_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;
	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface vlpd_out_if import vlpd_pkg::*; ;
	logic valid;
	logic ready;
	logic [1:0] out_kind;
	logic [7:0] out_byte;
	logic [LEN_W-1:0] frame_length;
	logic last;
	logic [1:0] err_code;
	modport source (output valid, output out_kind, output out_byte, output frame_length,
		output last, output err_code, input ready);
	modport sink (input valid, input out_kind, input out_byte, input frame_length,
		input last, input err_code, output ready);
endinterface

interface vlpd_cfg_if import vlpd_pkg::*; ;
	logic valid;
	logic ready;
	logic [LEN_W-1:0] max_frame_length;
	modport source (output valid, output max_frame_length, input ready);
	modport sink (input valid, input max_frame_length, output ready);
endinterface

[rtl/vlpd_decode.sv]
// header accumulation, length checks and payload countdown for one byte per cycle while accept is high
module vlpd_decode import vlpd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  logic [7:0] data_byte,
	input  logic [LEN_W-1:0] max_len,
	output logic res_valid,
	output result_t res
);

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_HALTED = 2'd2
	} phase_t;

	phase_t phase_q, phase_d;
	logic [LEN_W-1:0] acc_low_q, acc_low_d;
	logic acc_high_q, acc_high_d;
	logic [SHIFT_W-1:0] shift_q, shift_d;
	logic [LEN_W-1:0] remain_q, remain_d;

	logic [ACC_W-1:0] shifted;
	logic [LEN_W-1:0] new_low;
	logic new_high;
	logic [SHIFT_W:0] shift_sum;
	logic [LEN_W-1:0] remain_dec;

	assign shifted = ACC_W'(data_byte[6:0]) << shift_q;
	assign new_low = acc_low_q | shifted[LEN_W-1:0];
	assign new_high = acc_high_q | (|shifted[ACC_W-1:LEN_W]);
	assign shift_sum = {1'b0, shift_q} + (SHIFT_W+1)'(7);
	assign remain_dec = (remain_q == '0) ? '0 : remain_q - LEN_W'(1);

	always_comb begin
		phase_d = phase_q;
		acc_low_d = acc_low_q;
		acc_high_d = acc_high_q;
		shift_d = shift_q;
		remain_d = remain_q;
		res_valid = 1'b0;
		res = '0;
		case (phase_q)
			PH_HEADER: begin
				acc_low_d = new_low;
				acc_high_d = new_high;
				if (data_byte[7]) begin
					shift_d = shift_sum[SHIFT_W-1:0];
					if (shift_sum >= (SHIFT_W+1)'(ACC_W)) begin
						res_valid = 1'b1;
						res.out_kind = KIND_ERROR;
						res.err_code = ERR_TOO_LONG;
						phase_d = PH_HALTED;
					end
				end else if (!new_high && new_low == '0) begin
					res_valid = 1'b1;
					res.out_kind = KIND_ERROR;
					res.err_code = ERR_ZERO;
					phase_d = PH_HALTED;
				end else if (new_high || new_low > max_len) begin
					res_valid = 1'b1;
					res.out_kind = KIND_ERROR;
					res.err_code = ERR_TOO_LARGE;
					phase_d = PH_HALTED;
				end else begin
					res_valid = 1'b1;
					res.out_kind = KIND_LENGTH;
					res.frame_length = new_low;
					remain_d = new_low;
					acc_low_d = '0;
					acc_high_d = 1'b0;
					shift_d = '0;
					phase_d = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				remain_d = remain_dec;
				res_valid = 1'b1;
				res.out_kind = KIND_PAYLOAD;
				res.out_byte = data_byte;
				res.last = (remain_dec == '0);
				if (remain_dec == '0) begin
					acc_low_d = '0;
					acc_high_d = 1'b0;
					shift_d = '0;
					phase_d = PH_HEADER;
				end
			end
			default: begin
				phase_d = PH_HALTED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			acc_low_q <= '0;
			acc_high_q <= 1'b0;
			shift_q <= '0;
			remain_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			acc_low_q <= acc_low_d;
			acc_high_q <= acc_high_d;
			shift_q <= shift_d;
			remain_q <= remain_d;
		end
	end

endmodule

[rtl/vlpd_out_reg.sv]
// result register between the decoder and the output channel
module vlpd_out_reg import vlpd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  logic res_valid,
	input  result_t res,
	output logic take,
	vlpd_out_if.source out_ch
);

	logic valid_q;
	result_t res_q;

	assign take = !valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= accept && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && accept && res_valid) begin
			res_q <= res;
		end
	end

	assign out_ch.valid = valid_q;
	assign out_ch.out_kind = res_q.out_kind;
	assign out_ch.out_byte = res_q.out_byte;
	assign out_ch.frame_length = res_q.frame_length;
	assign out_ch.last = res_q.last;
	assign out_ch.err_code = res_q.err_code;

endmodule

[rtl/varint_length_prefix_deframer.sv]
// top level of the varint length-prefixed deframer
//
// in_ch carries raw stream bytes; each frame is a little-endian base-128
// varint length followed by that many payload bytes
// out_ch gives one beat per length, payload byte or error; continuation
// header bytes and bytes taken after an error give no beat
// cfg writes max_frame_length; it is always ready and takes effect at the
// next length check
// each result is registered and appears on out_ch in the cycle after its byte is taken
// throughput: one byte per cycle unless out_ch stalls, set by the single result register
// in_ch.ready is low only while a result waits and out_ch.ready is low;
// the next byte is taken in the same cycle the waiting result leaves
// after an error the block drops every byte until reset
// reset: header phase, empty accumulator, max_frame_length 1000000000,
// no result pending
module varint_length_prefix_deframer import vlpd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	vlpd_in_if.sink in_ch,
	vlpd_out_if.source out_ch,
	vlpd_cfg_if.sink cfg
);

	logic [LEN_W-1:0] max_len_q;
	logic take;
	logic accept;
	logic res_valid;
	result_t res;

	assign cfg.ready = 1'b1;
	assign in_ch.ready = take;
	assign accept = in_ch.valid && take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_FRAME_LEN_RST;
		end else if (cfg.valid) begin
			max_len_q <= cfg.max_frame_length;
		end
	end

	vlpd_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (in_ch.data_byte),
		.max_len   (max_len_q),
		.res_valid (res_valid),
		.res       (res)
	);

	vlpd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.res_valid (res_valid),
		.res       (res),
		.take      (take),
		.out_ch    (out_ch)
	);

endmodule
